[src/bqd_pkg.sv]
// Shared types, constants and microcode program for the biquad filter.
`default_nettype none
package bqd_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;
  localparam int COEF_W             = 18;
  localparam int STATE_W            = 36;
  localparam int NUM_STEPS          = 9;
  localparam int STEP_W             = $clog2(NUM_STEPS);
  localparam int CFG_IDX_W          = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CI_B0 = 3'd0,
    CI_B1 = 3'd1,
    CI_B2 = 3'd2,
    CI_A1 = 3'd3,
    CI_A2 = 3'd4
  } coef_idx_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LD_D1,
    ACC_LD_D2,
    ACC_LD_P,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic      wait_in;
    logic      ld_x;
    logic      mul_en;
    coef_idx_t coef_sel;
    logic      mul_y;
    acc_op_t   acc_op;
    logic      y_wr;
    logic      d1_wr;
    logic      d2_wr;
    logic      emit;
    logic      last;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } seq_stat_t;

  function automatic ctrl_t ucode_rom(logic [STEP_W-1:0] step);
    ctrl_t c;
    c.wait_in  = 1'b0;
    c.ld_x     = 1'b0;
    c.mul_en   = 1'b0;
    c.coef_sel = CI_B0;
    c.mul_y    = 1'b0;
    c.acc_op   = ACC_HOLD;
    c.y_wr     = 1'b0;
    c.d1_wr    = 1'b0;
    c.d2_wr    = 1'b0;
    c.emit     = 1'b0;
    c.last     = 1'b0;
    case (step)
      4'd0: begin
        c.wait_in = 1'b1;
        c.ld_x    = 1'b1;
        c.acc_op  = ACC_LD_D1;
      end
      4'd1: begin
        c.mul_en   = 1'b1;
        c.coef_sel = CI_B0;
      end
      4'd2: begin
        c.acc_op = ACC_ADD;
      end
      4'd3: begin
        c.y_wr     = 1'b1;
        c.mul_en   = 1'b1;
        c.coef_sel = CI_B1;
        c.acc_op   = ACC_LD_D2;
      end
      4'd4: begin
        c.acc_op   = ACC_ADD;
        c.mul_en   = 1'b1;
        c.coef_sel = CI_A1;
        c.mul_y    = 1'b1;
      end
      4'd5: begin
        c.acc_op   = ACC_SUB;
        c.mul_en   = 1'b1;
        c.coef_sel = CI_B2;
      end
      4'd6: begin
        c.d1_wr    = 1'b1;
        c.acc_op   = ACC_LD_P;
        c.mul_en   = 1'b1;
        c.coef_sel = CI_A2;
        c.mul_y    = 1'b1;
      end
      4'd7: begin
        c.acc_op = ACC_SUB;
      end
      4'd8: begin
        c.d2_wr = 1'b1;
        c.emit  = 1'b1;
        c.last  = 1'b1;
      end
      default: begin
        c.last = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[src/bqd_in_if.sv]
// Input sample channel: valid/ready handshake with one sample.
`default_nettype none
interface bqd_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface
`default_nettype wire

[src/bqd_out_if.sv]
// Result channel: valid/ready handshake with the filtered sample and clip flag.
`default_nettype none
interface bqd_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface
`default_nettype wire

[src/bqd_sequencer.sv]
// Microcode sequencer: step counter, program lookup and conditional holds.
`default_nettype none
module bqd_sequencer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bqd_pkg::seq_stat_t stat,
  output bqd_pkg::ctrl_t         ctrl,
  output logic                   fire
);
  import bqd_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;

  always_comb begin
    ctrl = ucode_rom(step_r);
    fire = 1'b1;
    if (ctrl.wait_in && !stat.in_valid) begin
      fire = 1'b0;
    end
    if (ctrl.emit && stat.out_busy) begin
      fire = 1'b0;
    end
    step_nxt = step_r;
    if (fire) begin
      step_nxt = ctrl.last ? '0 : step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
`default_nettype wire

[src/bqd_datapath.sv]
// Datapath: coefficient registers, shared multiplier, accumulator, state and output register.
`default_nettype none
module bqd_datapath #(
  parameter int SAMPLE_BITS    = bqd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bqd_pkg::ctrl_t                    ctrl,
  input  wire logic                              fire,
  input  wire logic                              cfg_we,
  input  wire logic [bqd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [bqd_pkg::COEF_W-1:0]        cfg_wdata,
  input  wire logic signed [SAMPLE_BITS-1:0]     x_in,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic signed [SAMPLE_BITS-1:0]          y_out,
  output logic                                   clip_out,
  output logic                                   out_busy
);
  import bqd_pkg::*;

  localparam int PROD_W = COEF_W + SAMPLE_BITS;
  localparam int ACC_W  = ((PROD_W > STATE_W) ? PROD_W : STATE_W) + 2;
  localparam logic signed [ACC_W-1:0] HALF_A =
    ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] Y_MAX_A =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] Y_MIN_A = -Y_MAX_A - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] ST_MAX_A =
    ACC_W'((64'sd1 <<< (STATE_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] ST_MIN_A = -ST_MAX_A - ACC_W'(1);
  localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [STATE_W-1:0] ST_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] ST_MIN = {1'b1, {(STATE_W-1){1'b0}}};

  logic signed [COEF_W-1:0]      b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic signed [PROD_W-1:0]      p_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       acc_nxt;
  logic signed [STATE_W-1:0]     d1_r, d2_r;
  logic                          hit_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] y_out_r;
  logic                          clip_out_r;

  logic signed [COEF_W-1:0]      coef_v;
  logic signed [SAMPLE_BITS-1:0] mul_b;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          y_hit;
  logic signed [STATE_W-1:0]     st_sat;
  logic                          st_hit;

  always_comb begin
    case (ctrl.coef_sel)
      CI_B0:   coef_v = b0_r;
      CI_B1:   coef_v = b1_r;
      CI_B2:   coef_v = b2_r;
      CI_A1:   coef_v = a1_r;
      CI_A2:   coef_v = a2_r;
      default: coef_v = b0_r;
    endcase
    mul_b = ctrl.mul_y ? y_r : x_r;
    prod  = PROD_W'(coef_v) * PROD_W'(mul_b);

    rnd   = (acc_r + HALF_A) >>> COEF_FRAC_BITS;
    y_hit = 1'b1;
    if (rnd > Y_MAX_A) begin
      y_sat = Y_MAX;
    end else if (rnd < Y_MIN_A) begin
      y_sat = Y_MIN;
    end else begin
      y_sat = rnd[SAMPLE_BITS-1:0];
      y_hit = 1'b0;
    end

    st_hit = 1'b1;
    if (acc_r > ST_MAX_A) begin
      st_sat = ST_MAX;
    end else if (acc_r < ST_MIN_A) begin
      st_sat = ST_MIN;
    end else begin
      st_sat = acc_r[STATE_W-1:0];
      st_hit = 1'b0;
    end

    case (ctrl.acc_op)
      ACC_HOLD:  acc_nxt = acc_r;
      ACC_LD_D1: acc_nxt = ACC_W'(d1_r);
      ACC_LD_D2: acc_nxt = ACC_W'(d2_r);
      ACC_LD_P:  acc_nxt = ACC_W'(p_r);
      ACC_ADD:   acc_nxt = acc_r + ACC_W'(p_r);
      ACC_SUB:   acc_nxt = acc_r - ACC_W'(p_r);
      default:   acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= COEF_W'(1 << COEF_FRAC_BITS);
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CI_B0:   b0_r <= cfg_wdata;
        CI_B1:   b1_r <= cfg_wdata;
        CI_B2:   b2_r <= cfg_wdata;
        CI_A1:   a1_r <= cfg_wdata;
        CI_A2:   a2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else if (fire) begin
      if (ctrl.d1_wr) begin
        d1_r <= st_sat;
      end
      if (ctrl.d2_wr) begin
        d2_r <= st_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_r <= acc_nxt;
      if (ctrl.ld_x) begin
        x_r   <= x_in;
        hit_r <= 1'b0;
      end
      if (ctrl.mul_en) begin
        p_r <= prod;
      end
      if (ctrl.y_wr) begin
        y_r   <= y_sat;
        hit_r <= hit_r | y_hit;
      end
      if (ctrl.d1_wr) begin
        hit_r <= hit_r | st_hit;
      end
      if (ctrl.emit) begin
        y_out_r    <= y_r;
        clip_out_r <= hit_r | st_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign y_out     = y_out_r;
  assign clip_out  = clip_out_r;
  assign out_busy  = out_valid_r & ~out_ready;

endmodule
`default_nettype wire

[src/biquad_iir_filter.sv]
// Biquad IIR filter, transposed direct form II, one shared multiplier under microcode.
// The input is taken at the first microcode step; the result is loaded into the output register at the last step.
// A new sample is taken only at the first step, after the last sample is done; five products share one multiplier.
// The next sample is taken while a result waits; a stalled output holds the last step.
// Reset (rst_n, synchronous): coefficients to b0 = 1.0, others 0; delay sums cleared.
`default_nettype none
module biquad_iir_filter #(
  parameter int SAMPLE_BITS    = bqd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  bqd_in_if.sink                             in_ch,
  bqd_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [bqd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [bqd_pkg::COEF_W-1:0]    cfg_wdata
);
  import bqd_pkg::*;

  ctrl_t     ctrl;
  logic      fire;
  seq_stat_t stat;
  logic      out_busy;

  assign stat.in_valid = in_ch.valid;
  assign stat.out_busy = out_busy;
  assign in_ch.ready   = ctrl.wait_in;

  bqd_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl),
    .fire  (fire)
  );

  bqd_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .fire      (fire),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .x_in      (in_ch.sample_in),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .y_out     (out_ch.sample_out),
    .clip_out  (out_ch.clipped),
    .out_busy  (out_busy)
  );

endmodule
`default_nettype wire

[bench/tb_biquad_iir_filter.sv]
// Self-checking testbench for biquad_iir_filter with a fixed-point scoreboard.
`default_nettype none
module tb_biquad_iir_filter;
  import bqd_pkg::*;

  localparam int SAMPLE_W    = SAMPLE_BITS_DEF;
  localparam int FRAC_W      = COEF_FRAC_BITS_DEF;
  localparam int NUM_COEFS   = int'(CI_A2) + 1;
  localparam int DUT_LATENCY = 9;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 135;
  localparam int REPORT_MAX  = 10;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1 << FRAC_W);
  localparam logic [COEF_W-1:0] COEF_HALF = COEF_W'(1 << (FRAC_W - 1));

  typedef enum {SET_RESET, SET_MAX, SET_MIN, SET_FIR, SET_STABLE, SET_WILD} coef_set_t;
  typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] y;
    logic                       clip;
  } filter_output_t;

  class filter_scoreboard;
    longint         coef [NUM_COEFS];
    longint         delay_first;
    longint         delay_second;
    bit             step_clipped;
    filter_output_t expected_out[$];
    int             mismatches;

    function new();
      coef[CI_B0]  = longint'(1) <<< FRAC_W;
      coef[CI_B1]  = 0;
      coef[CI_B2]  = 0;
      coef[CI_A1]  = 0;
      coef[CI_A2]  = 0;
      delay_first  = 0;
      delay_second = 0;
      mismatches   = 0;
    endfunction

    function void write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
      if (idx < NUM_COEFS) coef[idx] = longint'($signed(value));
    endfunction

    local function longint saturate(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        step_clipped = 1'b1;
        return hi;
      end
      if (v < lo) begin
        step_clipped = 1'b1;
        return lo;
      end
      return v;
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] x);
      longint         xs;
      longint         acc;
      longint         yv;
      longint         s1;
      longint         s2;
      filter_output_t r;
      xs = longint'(x);
      step_clipped = 1'b0;
      acc = coef[CI_B0] * xs + delay_first;
      yv = saturate((acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W, SAMPLE_W);
      s1 = coef[CI_B1] * xs - coef[CI_A1] * yv + delay_second;
      s2 = coef[CI_B2] * xs - coef[CI_A2] * yv;
      delay_first  = saturate(s1, STATE_W);
      delay_second = saturate(s2, STATE_W);
      r.y    = yv[SAMPLE_W-1:0];
      r.clip = step_clipped;
      expected_out.push_back(r);
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] y, logic clip);
      filter_output_t e;
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: unexpected output y=%0d clipped=%0b", y, clip);
        return;
      end
      e = expected_out.pop_front();
      if (e.y !== y || e.clip !== clip) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: output mismatch: expected y=%0d clipped=%0b, got y=%0d clipped=%0b",
                   e.y, e.clip, y, clip);
      end
    endfunction

    function int outstanding();
      return expected_out.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COEF_W-1:0]    cfg_wdata;
  bit                   hold_off;
  int                   cycle_count;
  filter_scoreboard     model;

  bqd_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_if ();
  bqd_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_if ();

  biquad_iir_filter #(
    .SAMPLE_BITS    (SAMPLE_W),
    .COEF_FRAC_BITS (FRAC_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      model.check_output(out_if.sample_out, out_if.clipped);
  end

  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       tick;
    mode      = RX_OPEN;
    mode_left = 0;
    tick      = 0;
    out_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      tick++;
      case (mode)
        RX_OPEN:     out_if.ready <= 1'b1;
        RX_COIN:     out_if.ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_if.ready <= (tick % 4 == 0);
        default:     out_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    in_if.valid     <= 1'b1;
    in_if.sample_in <= x;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    model.take_sample(x);
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (model.outstanding() != 0) @(negedge clk);
    repeat (DUT_LATENCY + 3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    model.write_coef(idx, value);
    @(negedge clk);
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                            input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                            input logic [COEF_W-1:0] a2);
    write_reg(CI_B0, b0);
    write_reg(CI_B1, b1);
    write_reg(CI_B2, b2);
    write_reg(CI_A1, a1);
    write_reg(CI_A2, a2);
    // unmapped indexes must leave the coefficients alone
    for (int i = NUM_COEFS; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), COEF_W'($urandom));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [COEF_W-1:0] rand_coef(input int span);
    return COEF_W'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic load_set(input coef_set_t kind);
    int a2;
    int a1_span;
    case (kind)
      SET_RESET: load_coefs(COEF_ONE, '0, '0, '0, '0);
      SET_MAX:   load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      SET_MIN:   load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      SET_FIR:   load_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom), '0, '0);
      SET_STABLE: begin
        a2      = int'($urandom_range(0, 28000)) - 14000;
        a1_span = ((1 << FRAC_W) + a2) * 9 / 10;
        load_coefs(rand_coef(8192), rand_coef(8192), rand_coef(8192),
                   rand_coef(a1_span), COEF_W'(a2));
      end
      default:   load_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                            COEF_W'($urandom), COEF_W'($urandom));
    endcase
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_W'($urandom_range(0, 4) - 2);
      3, 4, 5: return SAMPLE_W'($urandom_range(0, 4000) - 2000);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic stream_samples(input int count, input bit steady);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if (!steady && i != 0 && $urandom_range(0, 3) != 0) begin
          in_if.valid <= 1'b0;
          repeat ($urandom_range(1, 30)) @(negedge clk);
        end
      end
      send_sample(pick_sample());
      burst--;
    end
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] corner_x[7];
    logic signed [SAMPLE_W-1:0] half_x[5];
    coef_set_t                  plan[8];
    model           = new();
    cycle_count     = 0;
    hold_off        = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    corner_x = '{SAMPLE_MAX, SAMPLE_MIN, 0, 1, -1, 2, -2};
    half_x   = '{1, -1, 3, -3, SAMPLE_MAX};
    plan     = '{SET_STABLE, SET_WILD, SET_FIR, SET_STABLE, SET_MAX, SET_WILD, SET_MIN,
                 SET_RESET};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (corner_x[i]) send_sample(corner_x[i]);
    drain();
    // halfway points round up
    load_coefs(COEF_HALF, '0, '0, '0, '0);
    foreach (half_x[i]) send_sample(half_x[i]);
    drain();
    load_set(SET_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(0);
    drain();
    load_set(SET_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(1);

    foreach (plan[p]) begin
      drain();
      load_set(plan[p]);
      if (p == 3) hold_off = 1'b1;
      stream_samples(PHASE_ITEMS, p == 3 || $urandom_range(0, 2) == 0);
    end
    drain();

    if (model.mismatches == 0 && model.outstanding() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
